FILE: rtl/flr_pkg.sv
// Package for the link-layer register window: sizes, register map and constants.
// Holds the transfer item and access result types and the store address function.
// Depends on nothing; every other RTL file but flr_ram imports it.
`default_nettype none

package flr_pkg;

    // Sizes
    localparam int WINDOW_WORDS  = 16384;
    localparam int PHY_REG_COUNT = 16;
    localparam int ADDR_W        = $clog2(WINDOW_WORDS);
    localparam int PHY_AW        = $clog2(PHY_REG_COUNT);
    localparam int IDX_W         = 14;
    localparam int DATA_W        = 32;

    // Register map, as full word indices
    localparam logic [IDX_W-1:0] W_NODE_ID   = 14'h2100;
    localparam logic [IDX_W-1:0] W_CTRL0     = 14'h2102;
    localparam logic [IDX_W-1:0] W_CTRL2     = 14'h2104;
    localparam logic [IDX_W-1:0] W_PHYACC    = 14'h2105;
    localparam logic [IDX_W-1:0] W_INT0      = 14'h2108;
    localparam logic [IDX_W-1:0] W_INT0_MASK = 14'h2109;
    localparam logic [IDX_W-1:0] W_INT1      = 14'h210A;
    localparam logic [IDX_W-1:0] W_INT2      = 14'h210C;
    localparam logic [IDX_W-1:0] W_IDENTITY  = 14'h211F;

    // Store cells of the interrupt words, which live in flip-flops
    localparam logic [ADDR_W-1:0] CELL_INT0      = ADDR_W'(W_INT0 % WINDOW_WORDS);
    localparam logic [ADDR_W-1:0] CELL_INT0_MASK = ADDR_W'(W_INT0_MASK % WINDOW_WORDS);
    localparam logic [ADDR_W-1:0] CELL_INT1      = ADDR_W'(W_INT1 % WINDOW_WORDS);
    localparam logic [ADDR_W-1:0] CELL_INT2      = ADDR_W'(W_INT2 % WINDOW_WORDS);

    // Fixed read values and write rules
    localparam logic [DATA_W-1:0] NODE_ID_VALUE  = 32'hFFC0_0001;
    localparam logic [DATA_W-1:0] IDENTITY_VALUE = 32'h1000_0001;
    localparam logic [DATA_W-1:0] PHY_WR_CLEAR   = 32'h4000_FFFF;
    localparam logic [DATA_W-1:0] PHY_RD_FLAG    = 32'h8000_0000;
    localparam logic [DATA_W-1:0] INT_RX_FLAG    = 32'h4000_0000;
    localparam logic [DATA_W-1:0] CTRL0_DROP     = 32'h0080_0000;
    localparam logic [DATA_W-1:0] CTRL2_VALUE    = 32'h0000_0008;
    localparam int PHY_WR_POS     = 30;
    localparam int PHY_RD_POS     = 31;
    localparam int INT_RX_POS     = 30;
    localparam int PHY_WIDX_LSB   = 8;
    localparam int PHY_RIDX_LSB   = 24;
    localparam int PHY_FIELD_W    = 4;

    // One registered bus access
    typedef struct packed {
        logic              cmd;
        logic [IDX_W-1:0]  idx;
        logic [DATA_W-1:0] data;
        logic [ADDR_W-1:0] addr;
    } t_item;

    // What the access stage hands on to the result stage
    typedef struct packed {
        logic              use_ram;
        logic [DATA_W-1:0] value;
        logic              irq;
    } t_access_res;

    // Store cell of a word index: the index modulo the window size. The window
    // holds at least a quarter of the index range, so three subtracts suffice.
    function automatic logic [ADDR_W-1:0] cell_of(input logic [IDX_W-1:0] idx);
        logic [IDX_W:0] v;
        v = {1'b0, idx};
        for (int k = 0; k < 3; k++) begin
            if (v >= (IDX_W+1)'(WINDOW_WORDS)) begin
                v = v - (IDX_W+1)'(WINDOW_WORDS);
            end
        end
        return ADDR_W'(v);
    endfunction

endpackage

`default_nettype wire

FILE: rtl/flr_ram.sv
// Generic single-port RAM with a registered read port.
// Standalone; used for the register window's word store.
`default_nettype none

module flr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and read at one address per cycle; read data is registered.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: rtl/flr_regfile.sv
// Access stage: decodes one registered access, applies the write rules, and keeps
// the interrupt words and the PHY registers in flip-flops. Depends on flr_pkg.
`default_nettype none

module flr_regfile import flr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    input  t_item             i_item,
    output logic              o_ram_we,
    output logic [DATA_W-1:0] o_ram_wdata,
    output t_access_res       o_res
);

    logic [DATA_W-1:0] r_int0, r_mask, r_int1, r_int2;
    logic [DATA_W-1:0] n_int0, n_mask, n_int1, n_int2;
    logic [7:0]        r_phy [PHY_REG_COUNT];
    logic              phy_we;
    logic [PHY_AW-1:0] phy_widx;
    logic [PHY_AW-1:0] phy_ridx;
    logic [7:0]        phy_rval;

    assign phy_widx = i_item.data[PHY_WIDX_LSB +: PHY_AW];
    assign phy_ridx = i_item.data[PHY_RIDX_LSB +: PHY_AW];
    assign phy_rval = r_phy[phy_ridx];

    // Decode and write rules
    always_comb begin
        n_int0      = r_int0;
        n_mask      = r_mask;
        n_int1      = r_int1;
        n_int2      = r_int2;
        phy_we      = 1'b0;
        o_ram_we    = 1'b0;
        o_ram_wdata = i_item.data;
        o_res       = '0;
        if (i_vld) begin
            if (!i_item.cmd) begin
                // Read: fixed words by full index, interrupt cells from flops.
                if (i_item.idx == W_NODE_ID) begin
                    o_res.value = NODE_ID_VALUE;
                end else if (i_item.idx == W_IDENTITY) begin
                    o_res.value = IDENTITY_VALUE;
                end else if (i_item.addr == CELL_INT0) begin
                    o_res.value = r_int0;
                end else if (i_item.addr == CELL_INT0_MASK) begin
                    o_res.value = r_mask;
                end else if (i_item.addr == CELL_INT1) begin
                    o_res.value = r_int1;
                end else if (i_item.addr == CELL_INT2) begin
                    o_res.value = r_int2;
                end else begin
                    o_res.use_ram = 1'b1;
                end
            end else begin
                unique case (i_item.idx)
                    W_PHYACC: begin
                        o_ram_we = 1'b1;
                        if (i_item.data[PHY_WR_POS]) begin
                            // Indirect PHY write wins when both request bits are set.
                            phy_we      = 1'b1;
                            o_ram_wdata = i_item.data & ~PHY_WR_CLEAR;
                        end else if (i_item.data[PHY_RD_POS]) begin
                            o_ram_wdata = (i_item.data & ~PHY_RD_FLAG)
                                        | DATA_W'(phy_rval)
                                        | (DATA_W'(i_item.data[PHY_RIDX_LSB +: PHY_FIELD_W])
                                           << PHY_WIDX_LSB);
                            if (r_mask[INT_RX_POS]) begin
                                n_int0    = r_int0 | INT_RX_FLAG;
                                o_res.irq = 1'b1;
                            end
                        end
                    end
                    W_CTRL0: begin
                        o_ram_we    = 1'b1;
                        o_ram_wdata = i_item.data & ~CTRL0_DROP;
                    end
                    W_CTRL2: begin
                        o_ram_we    = 1'b1;
                        o_ram_wdata = CTRL2_VALUE;
                    end
                    W_INT0: begin
                        n_int0 = r_int0 & ~i_item.data;
                    end
                    W_INT1: begin
                        n_int1 = r_int1 & ~i_item.data;
                    end
                    W_INT2: begin
                        n_int2 = r_int2 & ~i_item.data;
                    end
                    default: begin
                        // Plain write; an interrupt cell reached this way is
                        // overwritten as it stands.
                        o_ram_we = 1'b1;
                        if (i_item.addr == CELL_INT0) begin
                            n_int0 = i_item.data;
                        end
                        if (i_item.addr == CELL_INT0_MASK) begin
                            n_mask = i_item.data;
                        end
                        if (i_item.addr == CELL_INT1) begin
                            n_int1 = i_item.data;
                        end
                        if (i_item.addr == CELL_INT2) begin
                            n_int2 = i_item.data;
                        end
                    end
                endcase
            end
        end
    end

    // Interrupt words and PHY registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_int0 <= '0;
            r_mask <= '0;
            r_int1 <= '0;
            r_int2 <= '0;
            for (int k = 0; k < PHY_REG_COUNT; k++) begin
                r_phy[k] <= '0;
            end
        end else begin
            r_int0 <= n_int0;
            r_mask <= n_mask;
            r_int1 <= n_int1;
            r_int2 <= n_int2;
            if (phy_we) begin
                r_phy[phy_widx] <= i_item.data[7:0];
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/firewire_link_register_block.sv
// Link-layer register window. A result strobe follows each taken access through the
// valid registers r_vld1, r_vld2 and r_vld3. Throughput: one access per cycle while
// busy is low; the word store has a single port and is read or written once per
// access. After reset, busy stays high while the store is cleared one word a cycle.
// The receiver cannot stall; each result is on the ports for one cycle.
`default_nettype none

module firewire_link_register_block import flr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              i_command,
    input  logic [IDX_W-1:0]  i_word_index,
    input  logic [DATA_W-1:0] i_write_data,
    output logic              o_valid,
    output logic [DATA_W-1:0] o_read_data,
    output logic              o_irq_raised
);

    logic              r_clearing;
    logic [ADDR_W-1:0] r_clr_addr;
    logic [ADDR_W-1:0] n_clr_addr;
    logic              r_vld1, r_vld2, r_vld3;
    t_item             r_item;
    t_access_res       r_res2;
    t_access_res       acc_res;
    logic [DATA_W-1:0] r_rdata, n_rdata;
    logic              r_irq;
    logic              accept;
    logic              acc_we;
    logic [DATA_W-1:0] acc_wdata;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_addr;
    logic [DATA_W-1:0] ram_wdata;
    logic [DATA_W-1:0] ram_rdata;

    assign accept = start && !r_clearing;
    assign busy   = r_clearing;

    // Clearing sweep after reset
    assign n_clr_addr = r_clr_addr + ADDR_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= n_clr_addr;
            if (r_clr_addr == ADDR_W'(WINDOW_WORDS - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    // Pipeline valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
        end else begin
            r_vld1 <= accept;
            r_vld2 <= r_vld1;
            r_vld3 <= r_vld2;
        end
    end

    // Input register: the transfer and its store cell
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.cmd  <= i_command;
            r_item.idx  <= i_word_index;
            r_item.data <= i_write_data;
            r_item.addr <= cell_of(i_word_index);
        end
    end

    flr_regfile u_regfile (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_vld       (r_vld1),
        .i_item      (r_item),
        .o_ram_we    (acc_we),
        .o_ram_wdata (acc_wdata),
        .o_res       (acc_res)
    );

    // Store port: the clearing sweep owns it until it ends
    assign ram_we    = r_clearing || acc_we;
    assign ram_addr  = r_clearing ? r_clr_addr : r_item.addr;
    assign ram_wdata = r_clearing ? '0 : acc_wdata;

    flr_ram #(
        .WIDTH (DATA_W),
        .DEPTH (WINDOW_WORDS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    // Result register: store data or the value picked by the access stage
    assign n_rdata = r_res2.use_ram ? ram_rdata : r_res2.value;

    always_ff @(posedge i_clk) begin
        r_res2  <= acc_res;
        r_rdata <= n_rdata;
        r_irq   <= r_res2.irq;
    end

    assign o_valid      = r_vld3;
    assign o_read_data  = r_rdata;
    assign o_irq_raised = r_irq;

endmodule

`default_nettype wire

FILE: rtl/flr_checker.sv
// Port-level checker for the link-layer register window, bound to the top level.
// Depends on flr_pkg for the register map and fixed read values.
`default_nettype none

module flr_checker import flr_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic              i_command,
    input logic [IDX_W-1:0]  i_word_index,
    input logic [DATA_W-1:0] i_write_data,
    input logic              o_valid,
    input logic [DATA_W-1:0] o_read_data,
    input logic              o_irq_raised
);

    // Every accepted transfer is followed by its result strobe.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##3 o_valid)
        else $error("result strobe missing after accepted transfer");

    // A write returns zero read data.
    a_write_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_command) |-> ##3 (o_read_data == '0))
        else $error("write returned nonzero read data");

    // A read never raises the interrupt.
    a_read_no_irq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !i_command) |-> ##3 !o_irq_raised)
        else $error("read raised the interrupt");

    // The node ID word reads its fixed value.
    a_node_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !i_command && (i_word_index == W_NODE_ID))
        |-> ##3 (o_read_data == NODE_ID_VALUE))
        else $error("node ID read returned wrong value");

endmodule

bind firewire_link_register_block flr_checker u_flr_checker (.*);

`default_nettype wire

FILE: bench/tb.sv
// Testbench for the link-layer register window: directed and random bus accesses,
// each result checked against a mirror of the word store and the PHY registers.
// Depends on rtl/flr_pkg.sv and rtl/firewire_link_register_block.sv.
`default_nettype none

module tb;
    import flr_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 1850;
    localparam int IDLE_PCT     = 7;
    localparam int POOL_SIZE    = 12;
    localparam int TAIL_CYCLES  = 8;

    // One expected access result
    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              irq_raised;
    } t_exp_result;

    logic              i_clk        = 1'b0;
    logic              i_rst_n      = 1'b0;
    logic              start        = 1'b0;
    logic              i_command    = 1'b0;
    logic [IDX_W-1:0]  i_word_index = '0;
    logic [DATA_W-1:0] i_write_data = '0;
    logic              busy;
    logic              o_valid;
    logic [DATA_W-1:0] o_read_data;
    logic              o_irq_raised;

    // Mirror of the block state and the results still in flight
    logic [DATA_W-1:0] mirror_words [WINDOW_WORDS];
    logic [7:0]        mirror_phy [PHY_REG_COUNT];
    t_exp_result       pending_results [$];
    logic [IDX_W-1:0]  address_pool [POOL_SIZE];
    logic [IDX_W-1:0]  special_words [9];

    int  fail_count = 0;
    int  cycle_count = 0;
    bit  idle_enabled = 1'b1;

    firewire_link_register_block dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_command    (i_command),
        .i_word_index (i_word_index),
        .i_write_data (i_write_data),
        .o_valid      (o_valid),
        .o_read_data  (o_read_data),
        .o_irq_raised (o_irq_raised)
    );

    always #4 i_clk = ~i_clk;

    // Run limit, reckoned from the store clearing pass plus every access at its slowest.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    // Work out the result of one access and update the mirrored state.
    function automatic t_exp_result predict_bus_access(input logic cmd,
                                                       input logic [IDX_W-1:0] idx,
                                                       input logic [DATA_W-1:0] data);
        t_exp_result       res;
        int unsigned       word;
        logic [DATA_W-1:0] acc;
        logic [3:0]        field;
        res = '0;
        word = idx % WINDOW_WORDS;
        if (!cmd) begin
            if (idx == W_NODE_ID) begin
                res.read_data = NODE_ID_VALUE;
            end else if (idx == W_IDENTITY) begin
                res.read_data = IDENTITY_VALUE;
            end else begin
                res.read_data = mirror_words[word];
            end
        end else begin
            case (idx)
                W_PHYACC: begin
                    acc = data;
                    if (data[PHY_WR_POS]) begin
                        field = data[PHY_WIDX_LSB +: PHY_FIELD_W];
                        mirror_phy[field % PHY_REG_COUNT] = data[7:0];
                        acc = acc & ~PHY_WR_CLEAR;
                    end else if (data[PHY_RD_POS]) begin
                        field = data[PHY_RIDX_LSB +: PHY_FIELD_W];
                        acc = acc & ~PHY_RD_FLAG;
                        acc = acc | DATA_W'(mirror_phy[field % PHY_REG_COUNT])
                                  | (DATA_W'(field) << PHY_WIDX_LSB);
                        // The receive interrupt latches only when its mask bit is set.
                        if (mirror_words[W_INT0_MASK % WINDOW_WORDS][INT_RX_POS]) begin
                            mirror_words[W_INT0 % WINDOW_WORDS] =
                                mirror_words[W_INT0 % WINDOW_WORDS] | INT_RX_FLAG;
                            res.irq_raised = 1'b1;
                        end
                    end
                    mirror_words[word] = acc;
                end
                W_CTRL0: begin
                    mirror_words[word] = data & ~CTRL0_DROP;
                end
                W_CTRL2: begin
                    mirror_words[word] = CTRL2_VALUE;
                end
                W_INT0, W_INT1, W_INT2: begin
                    mirror_words[word] = mirror_words[word] & ~data;
                end
                default: begin
                    mirror_words[word] = data;
                end
            endcase
        end
        return res;
    endfunction

    // Present one access, hold it until the block takes it, then record the expectation.
    task automatic send_access(input logic cmd, input logic [IDX_W-1:0] idx,
                               input logic [DATA_W-1:0] data);
        if (idle_enabled) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                start <= 1'b0;
                @(posedge i_clk);
            end
        end
        start        <= 1'b1;
        i_command    <= cmd;
        i_word_index <= idx;
        i_write_data <= data;
        @(posedge i_clk);
        while (busy) begin
            @(posedge i_clk);
        end
        pending_results.push_back(predict_bus_access(cmd, idx, data));
    endtask

    // Stop sending until every outstanding result has come back.
    task automatic wait_results_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Each result strobe is checked against the oldest expectation.
    always @(posedge i_clk) begin
        t_exp_result want;
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: read_data %h irq_raised %b",
                       o_read_data, o_irq_raised);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_read_data !== want.read_data) begin
                    $error("read_data: expected %h, got %h", want.read_data, o_read_data);
                    fail_count++;
                end
                if (o_irq_raised !== want.irq_raised) begin
                    $error("irq_raised: expected %b, got %b", want.irq_raised, o_irq_raised);
                    fail_count++;
                end
            end
        end
    end

    // Fixed read values and plain store words at both ends of the window.
    task automatic test_fixed_reads();
        send_access(1'b0, W_NODE_ID, 32'hFFFF_FFFF);
        send_access(1'b0, W_IDENTITY, 32'h0);
        send_access(1'b1, W_NODE_ID, 32'h1234_5678);
        send_access(1'b0, W_NODE_ID, 32'h0);
        send_access(1'b0, 14'h3FFF, 32'h0);
        send_access(1'b1, 14'h3FFF, 32'hFFFF_FFFF);
        send_access(1'b1, 14'h0000, 32'h0);
        send_access(1'b0, 14'h3FFF, 32'h0);
        send_access(1'b0, 14'h0000, 32'hFFFF_FFFF);
    endtask

    // Control 0 loses bit 23; a write to control 2 stores the fixed value.
    task automatic test_control_words();
        send_access(1'b1, W_CTRL0, 32'hFFFF_FFFF);
        send_access(1'b0, W_CTRL0, 32'h0);
        send_access(1'b1, W_CTRL2, 32'h1234_5678);
        send_access(1'b0, W_CTRL2, 32'h0);
    endtask

    // PHY writes and reads, the receive interrupt and its clear-on-write-one rule.
    task automatic test_phy_access();
        send_access(1'b1, W_PHYACC, 32'h7F00_0FA5);
        send_access(1'b0, W_PHYACC, 32'h0);
        send_access(1'b1, W_PHYACC, 32'h8F00_0000);
        send_access(1'b1, W_INT0_MASK, 32'h4000_0000);
        send_access(1'b1, W_PHYACC, 32'hBF12_3456);
        send_access(1'b0, W_INT0, 32'h0);
        // Both PHY request bits set: the write path takes precedence.
        send_access(1'b1, W_PHYACC, 32'hC000_033C);
        send_access(1'b1, W_PHYACC, 32'h8300_0000);
        send_access(1'b1, W_INT0, 32'h4000_0000);
        send_access(1'b0, W_INT0, 32'h0);
        send_access(1'b1, W_INT1, 32'hFFFF_FFFF);
        send_access(1'b1, W_INT2, 32'hFFFF_FFFF);
        send_access(1'b0, W_INT2, 32'h0);
    endtask

    // Random traffic, mostly on the special registers and a small set of words.
    task automatic test_random_traffic();
        int unsigned      pick;
        logic [IDX_W-1:0] idx;
        logic [DATA_W-1:0] data;
        logic             cmd;
        for (int k = 0; k < POOL_SIZE; k++) begin
            address_pool[k] = IDX_W'($urandom_range(16383));
        end
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // A long stretch with back-to-back transfers, with a full drain part way through.
            idle_enabled = !(n >= 600 && n < 1000);
            if (n == 900) begin
                wait_results_drained();
            end
            pick = $urandom_range(99);
            data = $urandom;
            cmd  = 1'($urandom_range(1));
            if (pick < 35) begin
                cmd = 1'b1;
                idx = W_PHYACC;
                data[PHY_RD_POS:PHY_WR_POS] = 2'($urandom_range(3));
            end else if (pick < 45) begin
                cmd = 1'b1;
                idx = special_words[3 + $urandom_range(4)];
            end else if (pick < 55) begin
                cmd = 1'b0;
                idx = special_words[$urandom_range(8)];
            end else if (pick < 62) begin
                cmd = 1'b1;
                idx = $urandom_range(1) ? W_CTRL0 : W_CTRL2;
            end else if (pick < 88) begin
                idx = address_pool[$urandom_range(POOL_SIZE - 1)];
            end else begin
                idx = IDX_W'($urandom);
            end
            send_access(cmd, idx, data);
        end
    endtask

    initial begin
        special_words = '{W_NODE_ID, W_IDENTITY, W_CTRL0, W_PHYACC, W_INT0,
                          W_INT0_MASK, W_INT1, W_INT2, W_CTRL2};
        for (int k = 0; k < WINDOW_WORDS; k++) begin
            mirror_words[k] = '0;
        end
        for (int k = 0; k < PHY_REG_COUNT; k++) begin
            mirror_phy[k] = '0;
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_fixed_reads();
        test_control_words();
        test_phy_access();
        wait_results_drained();
        test_random_traffic();

        // Let the last results drain, then let the pipeline run on before the verdict.
        wait_results_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: firewire_link_register_block.f
rtl/flr_pkg.sv
rtl/flr_ram.sv
rtl/flr_regfile.sv
rtl/firewire_link_register_block.sv
rtl/flr_checker.sv
bench/tb.sv
